// ===== src/fars_pkg.sv =====
package fars_pkg;

  localparam int FRAME_BYTES = 8;
  localparam int IDX_W       = $clog2(FRAME_BYTES);
  localparam int FRAME_W     = FRAME_BYTES * 8;
  localparam int ELAPSED_W   = 20;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_IDX_W   = 2;

  // command codes
  localparam logic [1:0] CMD_SEND = 2'd0;
  localparam logic [1:0] CMD_RX   = 2'd1;
  localparam logic [1:0] CMD_TICK = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_EN = 2'd2;

  localparam logic [15:0] INTERVAL_RST = 16'd500;
  localparam logic [7:0]  LIMIT_RST    = 8'd30;
  localparam logic        COUNT_EN_RST = 1'b1;

  // header bytes
  localparam logic [7:0] HDR_SYNC   = 8'hFE;
  localparam logic [7:0] HDR_LEN    = 8'h08;
  localparam logic [7:0] HDR_ID0    = 8'h01;
  localparam logic [7:0] HDR_ID1    = 8'h02;
  localparam logic [7:0] ACK_TYPE   = 8'h8F;
  localparam logic [7:0] ACK_MARK   = 8'hFF;

  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

  // one run handed from the core to the emitter
  typedef struct packed {
    logic               frame;
    logic [FRAME_W-1:0] data;
    logic               pending;
    logic               fail;
    logic               ack;
  } run_t;

endpackage

// ===== src/fars_if.sv =====
interface fars_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                cmd;
  logic [7:0]                rx_byte;
  logic [fars_pkg::FRAME_W-1:0] frame_word;

  modport source (output valid, cmd, rx_byte, frame_word, input ready);
  modport sink   (input valid, cmd, rx_byte, frame_word, output ready);
endinterface

interface fars_out_if;
  logic       valid;
  logic       ready;
  logic       tx_valid;
  logic [7:0] tx_byte;
  logic       last;
  logic       pending;
  logic       fail_event;
  logic       ack_event;

  modport source (output valid, tx_valid, tx_byte, last, pending, fail_event, ack_event,
                  input ready);
  modport sink   (input valid, tx_valid, tx_byte, last, pending, fail_event, ack_event,
                  output ready);
endinterface

// ===== src/frame_ack_resend_controller.sv =====
// channel   dir  payload                                          handshake
// in_chan   in   cmd, rx_byte, frame_word                         valid/ready
// out_chan  out  tx_valid, tx_byte, last, pending, fail/ack event  valid/ready
// cfg_*     in   cfg_index, cfg_data                              cfg_we, no wait
//
// one item per cycle while the skid entry is free; a send or resend gives eight results,
// one per cycle while out_chan.ready is high, anything else gives a single result
// the item updates state in the accepting cycle; its run waits in a two-deep
// run buffer (current plus skid) feeding out_chan from registers
// in_chan.ready drops only while the skid entry is occupied
// reset is synchronous and active low
module frame_ack_resend_controller (
  input  logic                             clk,
  input  logic                             rst_n,
  fars_in_if.sink                          in_chan,
  fars_out_if.source                       out_chan,
  input  logic                             cfg_we,
  input  logic [fars_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fars_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import fars_pkg::*;

  logic step;
  logic push_ready;
  run_t run;

  assign in_chan.ready = push_ready;
  assign step          = in_chan.valid && push_ready;

  fars_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .cmd        (in_chan.cmd),
    .rx_byte    (in_chan.rx_byte),
    .frame_word (in_chan.frame_word),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .run        (run)
  );

  fars_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (step),
    .run        (run),
    .push_ready (push_ready),
    .out_chan   (out_chan)
  );

  assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.fail_event |-> out_chan.tx_valid && !out_chan.pending)
    else $error("failure without resend bytes or with frame still pending");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && out_chan.ack_event |-> !out_chan.tx_valid && !out_chan.pending)
    else $error("acknowledge result inconsistent");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid && !out_chan.tx_valid |-> out_chan.last && out_chan.tx_byte == 8'd0)
    else $error("empty result must be a single last result");

  assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> out_chan.valid)
    else $error("input stalled with nothing to deliver");

endmodule

// ===== src/fars_core.sv =====
module fars_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic [1:0]                    cmd,
  input  logic [7:0]                    rx_byte,
  input  logic [fars_pkg::FRAME_W-1:0]  frame_word,
  input  logic                          cfg_we,
  input  logic [fars_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fars_pkg::CFG_DATA_W-1:0] cfg_data,
  output fars_pkg::run_t                run
);
  import fars_pkg::*;

  logic [15:0]          interval_r;
  logic [7:0]           limit_r;
  logic                 count_en_r;

  logic [2:0]           hdr_pos_r, hdr_pos_nxt;
  logic [7:0]           type_byte_r, type_byte_nxt;
  logic                 ack_lat_r, ack_lat_nxt;
  logic                 pending_r, pending_nxt;
  logic                 timing_r, timing_nxt;
  logic [ELAPSED_W-1:0] elapsed_r, elapsed_nxt;
  logic [7:0]           resend_cnt_r, resend_cnt_nxt;
  logic [FRAME_W-1:0]   frame_r, frame_nxt;

  logic [ELAPSED_W-1:0] limit_ticks;
  logic [ELAPSED_W-1:0] elapsed_inc;
  logic [7:0]           cnt_inc;

  // interval * 10 as two shifted adds, fits in the elapsed width
  assign limit_ticks = {1'b0, interval_r, 3'b000} + {3'b000, interval_r, 1'b0};
  assign elapsed_inc = (elapsed_r == ELAPSED_MAX) ? elapsed_r : elapsed_r + 1'b1;
  assign cnt_inc     = resend_cnt_r + 8'd1;

  always_comb begin
    hdr_pos_nxt    = hdr_pos_r;
    type_byte_nxt  = type_byte_r;
    ack_lat_nxt    = ack_lat_r;
    pending_nxt    = pending_r;
    timing_nxt     = timing_r;
    elapsed_nxt    = elapsed_r;
    resend_cnt_nxt = resend_cnt_r;
    frame_nxt      = frame_r;
    run.frame      = 1'b0;
    run.data       = frame_r;
    run.fail       = 1'b0;
    run.ack        = 1'b0;
    case (cmd)
      CMD_SEND: begin
        frame_nxt   = frame_word;
        ack_lat_nxt = 1'b0;
        pending_nxt = 1'b1;
        run.frame   = 1'b1;
        run.data    = frame_word;
      end
      CMD_RX: begin
        case (hdr_pos_r)
          3'd0: hdr_pos_nxt = (rx_byte == HDR_SYNC) ? 3'd1 : 3'd0;
          3'd1: hdr_pos_nxt = (rx_byte == HDR_LEN) ? 3'd2 : 3'd0;
          3'd2: hdr_pos_nxt = 3'd3;
          3'd3: hdr_pos_nxt = 3'd4;
          3'd4: hdr_pos_nxt = (rx_byte == HDR_ID0) ? 3'd5 : 3'd0;
          3'd5: hdr_pos_nxt = (rx_byte == HDR_ID1) ? 3'd6 : 3'd0;
          3'd6: begin
            type_byte_nxt = rx_byte;
            hdr_pos_nxt   = 3'd7;
          end
          default: begin
            if (type_byte_r == ACK_TYPE && rx_byte == ACK_MARK) begin
              ack_lat_nxt = 1'b1;
            end
            hdr_pos_nxt = 3'd0;
          end
        endcase
      end
      CMD_TICK: begin
        if (pending_r) begin
          if (ack_lat_r) begin
            ack_lat_nxt    = 1'b0;
            pending_nxt    = 1'b0;
            timing_nxt     = 1'b0;
            elapsed_nxt    = '0;
            resend_cnt_nxt = '0;
            run.ack        = 1'b1;
          end else if (!timing_r) begin
            timing_nxt  = 1'b1;
            elapsed_nxt = '0;
          end else if (elapsed_inc > limit_ticks) begin
            timing_nxt  = 1'b0;
            elapsed_nxt = '0;
            run.frame   = 1'b1;
            if (count_en_r) begin
              if (cnt_inc >= limit_r) begin
                resend_cnt_nxt = '0;
                pending_nxt    = 1'b0;
                run.fail       = 1'b1;
              end else begin
                resend_cnt_nxt = cnt_inc;
              end
            end else begin
              resend_cnt_nxt = '0;
            end
          end else begin
            elapsed_nxt = elapsed_inc;
          end
        end
      end
      default: begin
      end
    endcase
    run.pending = pending_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r   <= INTERVAL_RST;
      limit_r      <= LIMIT_RST;
      count_en_r   <= COUNT_EN_RST;
      hdr_pos_r    <= '0;
      type_byte_r  <= '0;
      ack_lat_r    <= 1'b0;
      pending_r    <= 1'b0;
      timing_r     <= 1'b0;
      elapsed_r    <= '0;
      resend_cnt_r <= '0;
      frame_r      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_INTERVAL: interval_r <= cfg_data;
          REG_LIMIT:    limit_r    <= cfg_data[7:0];
          REG_COUNT_EN: count_en_r <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (step) begin
        hdr_pos_r    <= hdr_pos_nxt;
        type_byte_r  <= type_byte_nxt;
        ack_lat_r    <= ack_lat_nxt;
        pending_r    <= pending_nxt;
        timing_r     <= timing_nxt;
        elapsed_r    <= elapsed_nxt;
        resend_cnt_r <= resend_cnt_nxt;
        frame_r      <= frame_nxt;
      end
    end
  end

endmodule

// ===== src/fars_emit.sv =====
module fars_emit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  fars_pkg::run_t run,
  output logic           push_ready,
  fars_out_if.source     out_chan
);
  import fars_pkg::*;

  logic             cur_vld_r, cur_vld_nxt;
  run_t             cur_r, cur_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             skid_vld_r, skid_vld_nxt;
  run_t             skid_r, skid_nxt;
  logic             take, is_last, done;

  assign is_last = !cur_r.frame || (idx_r == IDX_W'(FRAME_BYTES - 1));
  assign take    = cur_vld_r && out_chan.ready;
  assign done    = take && is_last;

  assign push_ready          = !skid_vld_r;
  assign out_chan.valid      = cur_vld_r;
  assign out_chan.tx_valid   = cur_r.frame;
  assign out_chan.tx_byte    = cur_r.frame ? cur_r.data[idx_r*8 +: 8] : 8'd0;
  assign out_chan.last       = is_last;
  assign out_chan.pending    = cur_r.pending;
  assign out_chan.fail_event = cur_r.fail;
  assign out_chan.ack_event  = cur_r.ack;

  always_comb begin
    cur_vld_nxt  = cur_vld_r;
    cur_nxt      = cur_r;
    idx_nxt      = idx_r;
    skid_vld_nxt = skid_vld_r;
    skid_nxt     = skid_r;
    if (!cur_vld_r) begin
      if (push) begin
        cur_vld_nxt = 1'b1;
        cur_nxt     = run;
        idx_nxt     = '0;
      end
    end else if (done) begin
      idx_nxt = '0;
      if (skid_vld_r) begin
        cur_nxt      = skid_r;
        skid_vld_nxt = push;
        skid_nxt     = run;
      end else begin
        cur_vld_nxt = push;
        cur_nxt     = run;
      end
    end else begin
      if (take) begin
        idx_nxt = idx_r + 1'b1;
      end
      if (push) begin
        skid_vld_nxt = 1'b1;
        skid_nxt     = run;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
      idx_r      <= '0;
    end else begin
      cur_vld_r  <= cur_vld_nxt;
      skid_vld_r <= skid_vld_nxt;
      idx_r      <= idx_nxt;
    end
    cur_r  <= cur_nxt;
    skid_r <= skid_nxt;
  end

endmodule

// ===== test/frame_ack_resend_controller_tb.sv =====
`timescale 1ns / 100ps

module frame_ack_resend_controller_tb;
  import fars_pkg::*;

  localparam logic [1:0] CMD_NONE       = 2'd3;
  localparam int         TICKS_PER_UNIT = 10;
  localparam int         STALL_LIMIT    = 1000;
  localparam int         PHASE_ITEMS    = 55;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       last;
    logic       pending;
    logic       fail;
    logic       ack;
  } tx_result_t;

  // retransmit predictor plus the queue of transmit results still owed
  class resend_scoreboard;
    logic [15:0]          interval = INTERVAL_RST;
    logic [7:0]           limit    = LIMIT_RST;
    logic                 count_en = COUNT_EN_RST;
    logic [2:0]           hdr_pos  = '0;
    logic [7:0]           type_byte = '0;
    bit                   ack_held;
    bit                   pend;
    bit                   timing;
    logic [ELAPSED_W-1:0] elapsed = '0;
    logic [7:0]           resends = '0;
    logic [FRAME_W-1:0]   frame   = '0;
    tx_result_t           due[$];
    int                   mismatches;

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_INTERVAL: interval = data;
        REG_LIMIT:    limit    = data[7:0];
        REG_COUNT_EN: count_en = data[0];
        default: ;
      endcase
    endfunction

    function void note_input(logic [1:0] cmd, logic [7:0] rxb, logic [FRAME_W-1:0] word);
      bit fail;
      bit ack;
      bit burst;
      fail  = 1'b0;
      ack   = 1'b0;
      burst = 1'b0;
      case (cmd)
        CMD_SEND: begin
          frame    = word;
          ack_held = 1'b0;
          pend     = 1'b1;
          burst    = 1'b1;
        end
        CMD_RX: begin
          // a mismatch drops back to the start without re-testing the byte
          case (hdr_pos)
            3'd0: hdr_pos = (rxb == HDR_SYNC) ? 3'd1 : 3'd0;
            3'd1: hdr_pos = (rxb == HDR_LEN) ? 3'd2 : 3'd0;
            3'd2: hdr_pos = 3'd3;
            3'd3: hdr_pos = 3'd4;
            3'd4: hdr_pos = (rxb == HDR_ID0) ? 3'd5 : 3'd0;
            3'd5: hdr_pos = (rxb == HDR_ID1) ? 3'd6 : 3'd0;
            3'd6: begin
              type_byte = rxb;
              hdr_pos   = 3'd7;
            end
            default: begin
              if (type_byte == ACK_TYPE && rxb == ACK_MARK) ack_held = 1'b1;
              hdr_pos = 3'd0;
            end
          endcase
        end
        CMD_TICK: begin
          if (pend) begin
            if (ack_held) begin
              ack_held = 1'b0;
              pend     = 1'b0;
              timing   = 1'b0;
              elapsed  = '0;
              resends  = '0;
              ack      = 1'b1;
            end else if (!timing) begin
              timing  = 1'b1;
              elapsed = '0;
            end else begin
              if (elapsed != ELAPSED_MAX) elapsed++;
              if (int'(elapsed) > int'(interval) * TICKS_PER_UNIT) begin
                timing  = 1'b0;
                elapsed = '0;
                burst   = 1'b1;
                if (count_en) begin
                  resends++;
                  if (resends >= limit) begin
                    resends = '0;
                    pend    = 1'b0;
                    fail    = 1'b1;
                  end
                end else begin
                  resends = '0;
                end
              end
            end
          end
        end
        default: ;
      endcase
      if (burst) begin
        for (int k = 0; k < FRAME_BYTES; k++)
          due.push_back('{1'b1, frame[8*k +: 8], k == FRAME_BYTES - 1, pend, fail, 1'b0});
      end else begin
        due.push_back('{1'b0, 8'h00, 1'b1, pend, 1'b0, ack});
      end
    endfunction

    function string show(tx_result_t r);
      return $sformatf("tx_valid=%0b tx_byte=%h last=%0b pending=%0b fail=%0b ack=%0b",
                       r.tx_valid, r.tx_byte, r.last, r.pending, r.fail, r.ack);
    endfunction

    function void check_result(tx_result_t got);
      tx_result_t want;
      if (due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("%0t: unexpected result %s", $time, show(got));
        return;
      end
      want = due.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result mismatch\n  expected %s\n  actual   %s",
                   $time, show(want), show(got));
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  fars_in_if  in_ch ();
  fars_out_if out_ch ();

  resend_scoreboard sb = new;
  int items_sent = 0;
  int calm_in    = 0;
  int calm_out   = 0;
  int idle_cycles = 0;

  frame_ack_resend_controller u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_ch),
    .out_chan  (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // gap before the next item, with occasional runs of back-to-back traffic
  function automatic int draw_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(8, 32);
      return 0;
    end
    return $urandom_range(0, 8);
  endfunction

  task automatic push_item(logic [1:0] cmd, logic [7:0] rxb, logic [FRAME_W-1:0] word);
    int gap;
    gap = draw_wait(calm_in);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= cmd;
    in_ch.rx_byte    <= rxb;
    in_ch.frame_word <= word;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_input(cmd, rxb, word);
    if (cmd != CMD_NONE) items_sent++;
  endtask

  task automatic push_rx(logic [7:0] b);
    push_item(CMD_RX, b, {$urandom, $urandom});
  endtask

  task automatic push_tick();
    push_item(CMD_TICK, 8'($urandom), {$urandom, $urandom});
  endtask

  // first len bytes of a header; acking picks the acknowledge type and mark
  task automatic push_header(int len, bit acking);
    logic [7:0] hdr [FRAME_BYTES];
    int         k;
    hdr = '{HDR_SYNC, HDR_LEN, 8'($urandom), 8'($urandom), HDR_ID0, HDR_ID1,
            acking ? ACK_TYPE : 8'($urandom), acking ? ACK_MARK : 8'($urandom)};
    for (k = 0; k < len; k++) push_rx(hdr[k]);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task automatic program_regs(logic [15:0] interval, logic [7:0] limit, logic count_en);
    write_reg(REG_INTERVAL, interval);
    write_reg(REG_LIMIT, {8'd0, limit});
    write_reg(REG_COUNT_EN, {15'd0, count_en});
    cfg_we <= 1'b0;
  endtask

  task automatic random_traffic(int n);
    int target;
    int r;
    target = items_sent + n;
    while (items_sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        push_item(CMD_SEND, 8'($urandom), {$urandom, $urandom});
      end else if (r < 64) begin
        push_tick();
      end else if (r < 69) begin
        push_header(FRAME_BYTES, 1'b1);
      end else if (r < 74) begin
        push_header(FRAME_BYTES, 1'b0);
      end else if (r < 84) begin
        push_header($urandom_range(1, FRAME_BYTES - 1), 1'b1);
        push_rx(8'($urandom));
      end else if (r < 95) begin
        push_rx(8'($urandom));
      end else begin
        push_item(CMD_NONE, 8'($urandom), {$urandom, $urandom});
      end
    end
  endtask

  // result side: random stalls between items
  initial begin
    int         stall;
    tx_result_t got;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      stall = draw_wait(calm_out);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      got = '{out_ch.tx_valid, out_ch.tx_byte, out_ch.last, out_ch.pending,
              out_ch.fail_event, out_ch.ack_event};
      sb.check_result(got);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("frame_ack_resend_controller_tb: errors");
      $finish;
    end
  end

  initial begin
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.cmd        <= CMD_TICK;
    in_ch.rx_byte    <= '0;
    in_ch.frame_word <= '0;
    cfg_we           <= 1'b0;
    cfg_index        <= REG_INTERVAL;
    cfg_data         <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: idle tick, unused command, all-zero and all-ones frames
    push_tick();
    push_item(CMD_NONE, 8'hFF, '1);
    push_item(CMD_SEND, 8'h00, '0);
    push_header(FRAME_BYTES, 1'b1);
    // a new send while pending must clear the latched acknowledge
    push_item(CMD_SEND, 8'hFF, '1);
    push_tick();
    // doubled sync byte: the second one is not taken as a fresh start
    push_rx(HDR_SYNC);
    push_header(FRAME_BYTES, 1'b1);
    push_tick();
    drain();

    // zero interval and zero limit: drop on the very next resend
    program_regs(16'd0, 8'd0, 1'b1);
    push_tick();
    push_tick();

    for (int p = 0; p < 5; p++) begin
      drain();
      case (p)
        0:       program_regs(16'd1, 8'd1, 1'b1);
        1:       program_regs(16'd2, 8'd255, 1'b1);
        2:       program_regs(16'hFFFF, 8'd255, 1'b0);
        default: program_regs(16'($urandom_range(1, 4)), 8'($urandom_range(1, 6)),
                              1'($urandom_range(0, 1)));
      endcase
      random_traffic(PHASE_ITEMS);
    end

    drain();
    repeat (10) @(posedge clk);
    if (sb.mismatches == 0 && sb.due.size() == 0) begin
      $display("frame_ack_resend_controller_tb: clean");
    end else begin
      $display("frame_ack_resend_controller_tb: errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
src/fars_pkg.sv
src/fars_if.sv
src/fars_core.sv
src/fars_emit.sv
src/frame_ack_resend_controller.sv
test/frame_ack_resend_controller_tb.sv
